// ===== rtl/hsl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the HSL to RGB converter.
// No dependencies; every other file imports this package.
package hsl_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int FIELD_W    = 13;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int IN_W       = (FIELD_W > VAL_W) ? FIELD_W : VAL_W;
    localparam int NUM_STAGES = 6;

    typedef logic [VAL_W-1:0]      frac_t;
    typedef logic [NUM_STAGES-1:0] stage_en_t;

    localparam frac_t ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam frac_t THIRD = VAL_W'((2 ** FRAC_BITS) / 3);

    typedef enum logic [1:0] {
        RG_RISE,
        RG_HIGH,
        RG_FALL,
        RG_LOW
    } region_t;

    typedef struct packed {
        frac_t p;
        frac_t q;
        frac_t d;
        frac_t l;
        logic  achrom;
    } qp_t;

    function automatic frac_t clamp_in(logic [FIELD_W-1:0] v);
        logic [IN_W-1:0] w;
        w = IN_W'(v);
        if (w > IN_W'(ONE)) begin
            return ONE;
        end
        return VAL_W'(w);
    endfunction

endpackage

// ===== rtl/hsl_front.sv =====
`timescale 1ns / 1ps
// Input stage: clamps the three fractions and forms the wrapped hue for each channel.
// Depends on hsl_pkg.
module hsl_front import hsl_pkg::*; (
    input  logic                 aclk,
    input  stage_en_t            stage_en,
    input  logic [FIELD_W-1:0]   hue,
    input  logic [FIELD_W-1:0]   saturation,
    input  logic [FIELD_W-1:0]   lightness,
    output frac_t                t_red,
    output frac_t                t_green,
    output frac_t                t_blue,
    output frac_t                sat,
    output frac_t                light
);

    frac_t            h_c;
    logic [VAL_W:0]   h_plus;
    frac_t            t_red_next;
    frac_t            t_blue_next;
    frac_t            t_red_reg;
    frac_t            t_green_reg;
    frac_t            t_blue_reg;
    frac_t            sat_reg;
    frac_t            light_reg;

    always_comb begin
        h_c    = clamp_in(hue);
        h_plus = {1'b0, h_c} + {1'b0, THIRD};
        if (h_plus > {1'b0, ONE}) begin
            t_red_next = VAL_W'(h_plus - {1'b0, ONE});
        end else begin
            t_red_next = VAL_W'(h_plus);
        end
        if (h_c < THIRD) begin
            t_blue_next = VAL_W'({1'b0, h_c} + {1'b0, ONE} - {1'b0, THIRD});
        end else begin
            t_blue_next = h_c - THIRD;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t_red_reg   <= t_red_next;
            t_green_reg <= h_c;
            t_blue_reg  <= t_blue_next;
            sat_reg     <= clamp_in(saturation);
            light_reg   <= clamp_in(lightness);
        end
    end

    assign t_red   = t_red_reg;
    assign t_green = t_green_reg;
    assign t_blue  = t_blue_reg;
    assign sat     = sat_reg;
    assign light   = light_reg;

endmodule

// ===== rtl/hsl_qp.sv =====
`timescale 1ns / 1ps
// Forms the ramp bounds q and p and their difference over three pipeline stages.
// Depends on hsl_pkg.
module hsl_qp import hsl_pkg::*; (
    input  logic      aclk,
    input  stage_en_t stage_en,
    input  frac_t     sat,
    input  frac_t     light,
    output qp_t       bounds
);

    localparam int PW = 2 * VAL_W + 1;
    localparam int QW = VAL_W + 2;

    logic                 low;
    logic [VAL_W:0]       mult_b;
    logic [PW-1:0]        prod_next;
    logic [PW-1:0]        prod_reg;
    logic                 low_reg;
    logic                 achrom1_reg;
    frac_t                l1_reg;
    frac_t                s1_reg;

    logic [QW-1:0]        q_raw;
    frac_t                q_next;
    frac_t                q2_reg;
    frac_t                l2_reg;
    logic                 achrom2_reg;

    logic signed [QW-1:0] pd;
    frac_t                p_next;
    qp_t                  bounds_reg;

    always_comb begin
        low       = {light, 1'b0} < {1'b0, ONE};
        mult_b    = low ? ({1'b0, ONE} + {1'b0, sat}) : {1'b0, sat};
        prod_next = PW'(light) * PW'(mult_b);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg    <= prod_next;
            low_reg     <= low;
            achrom1_reg <= (sat == '0);
            l1_reg      <= light;
            s1_reg      <= sat;
        end
    end

    always_comb begin
        if (low_reg) begin
            q_raw = QW'(prod_reg >> FRAC_BITS);
        end else begin
            q_raw = QW'(l1_reg) + QW'(s1_reg) - QW'(prod_reg >> FRAC_BITS);
        end
        if (q_raw > QW'(ONE)) begin
            q_next = ONE;
        end else begin
            q_next = VAL_W'(q_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            q2_reg      <= q_next;
            l2_reg      <= l1_reg;
            achrom2_reg <= achrom1_reg;
        end
    end

    always_comb begin
        pd = $signed({1'b0, l2_reg, 1'b0}) - $signed({2'b00, q2_reg});
        if (pd < 0) begin
            p_next = '0;
        end else if (pd > $signed(QW'(ONE))) begin
            p_next = ONE;
        end else begin
            p_next = VAL_W'(pd);
        end
        if (p_next > q2_reg) begin
            p_next = q2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            bounds_reg.p      <= p_next;
            bounds_reg.q      <= q2_reg;
            bounds_reg.d      <= q2_reg - p_next;
            bounds_reg.l      <= l2_reg;
            bounds_reg.achrom <= achrom2_reg;
        end
    end

    assign bounds = bounds_reg;

endmodule

// ===== rtl/hsl_ramp.sv =====
`timescale 1ns / 1ps
// One colour channel: classifies its hue into a ramp segment, scales the
// bound difference and forms the clamped channel value. Depends on hsl_pkg.
module hsl_ramp import hsl_pkg::*; (
    input  logic      aclk,
    input  stage_en_t stage_en,
    input  frac_t     t_in,
    input  qp_t       bounds,
    output frac_t     value
);

    localparam int TW = VAL_W + 3;
    localparam int MW = 2 * VAL_W;

    logic [TW-1:0]  t6;
    logic [VAL_W:0] t2;
    logic [VAL_W+1:0] t3;
    region_t        region_next;
    frac_t          factor_next;

    region_t        region1_reg;
    region_t        region2_reg;
    region_t        region3_reg;
    region_t        region4_reg;
    frac_t          factor1_reg;
    frac_t          factor2_reg;
    frac_t          factor3_reg;

    logic [MW-1:0]  prod_reg;
    frac_t          p4_reg;
    frac_t          q4_reg;
    frac_t          l4_reg;
    logic           achrom4_reg;

    logic [VAL_W:0] sum;
    frac_t          value_next;
    frac_t          value_reg;

    always_comb begin
        t6 = (TW'(t_in) << 2) + (TW'(t_in) << 1);
        t2 = {t_in, 1'b0};
        t3 = {1'b0, t_in, 1'b0} + {2'b00, t_in};
        factor_next = '0;
        if (t6 < TW'(ONE)) begin
            region_next = RG_RISE;
            factor_next = VAL_W'(t6);
        end else if (t2 < {1'b0, ONE}) begin
            region_next = RG_HIGH;
        end else if (t3 < {1'b0, ONE, 1'b0}) begin
            region_next = RG_FALL;
            factor_next = VAL_W'((TW'(ONE) << 2) - t6);
        end else begin
            region_next = RG_LOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            region1_reg <= region_next;
            factor1_reg <= factor_next;
        end
        if (stage_en[2]) begin
            region2_reg <= region1_reg;
            factor2_reg <= factor1_reg;
        end
        if (stage_en[3]) begin
            region3_reg <= region2_reg;
            factor3_reg <= factor2_reg;
        end
        if (stage_en[4]) begin
            prod_reg    <= MW'(bounds.d) * MW'(factor3_reg);
            region4_reg <= region3_reg;
            p4_reg      <= bounds.p;
            q4_reg      <= bounds.q;
            l4_reg      <= bounds.l;
            achrom4_reg <= bounds.achrom;
        end
    end

    always_comb begin
        sum = {1'b0, p4_reg} + (VAL_W + 1)'(prod_reg >> FRAC_BITS);
        case (region4_reg)
            RG_RISE, RG_FALL: begin
                value_next = (sum > {1'b0, ONE}) ? ONE : VAL_W'(sum);
            end
            RG_HIGH: begin
                value_next = q4_reg;
            end
            default: begin
                value_next = p4_reg;
            end
        endcase
        if (achrom4_reg) begin
            value_next = l4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// HSL to RGB converter, top level: valid/ready pipeline control and the
// front, bound and per-channel ramp units. Depends on hsl_pkg and all hsl_ modules.
//
// Usage: a request on the s_ channel carries hue, saturation and lightness
// as unsigned fractions in which 4096 stands for 1.0; larger values are
// treated as 1.0. Each request yields exactly one m_ request carrying red,
// green and blue in the same format, in the order the inputs arrived.
// The accepting edge loads the pixel into the first of six register stages.
// The stages are the input clamp and hue wrap, q/p multiply, q clamp,
// p and difference, channel multiply, and the final add and clamp in the
// output register. Throughput is one pixel per clock while m_ready is high.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and s_ready stays high while any stage is free.
// When the receiver holds m_ready low the pipeline fills, and s_ready falls
// only once all six stages hold a pixel; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline; data registers
// are not cleared and carry no meaning until their valid bits are set.
module hsl_to_rgb_converter import hsl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_hue,
    input  logic [FIELD_W-1:0] s_saturation,
    input  logic [FIELD_W-1:0] s_lightness,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_red,
    output logic [FIELD_W-1:0] m_green,
    output logic [FIELD_W-1:0] m_blue
);

    stage_en_t stage_en;
    stage_en_t vld_reg;
    stage_en_t vld_next;

    frac_t t_red;
    frac_t t_green;
    frac_t t_blue;
    frac_t sat;
    frac_t light;
    qp_t   bounds;
    frac_t red_val;
    frac_t green_val;
    frac_t blue_val;

    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    hsl_front u_front (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .hue        (s_hue),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .t_red      (t_red),
        .t_green    (t_green),
        .t_blue     (t_blue),
        .sat        (sat),
        .light      (light)
    );

    hsl_qp u_qp (
        .aclk     (aclk),
        .stage_en (stage_en),
        .sat      (sat),
        .light    (light),
        .bounds   (bounds)
    );

    hsl_ramp u_ramp_red (
        .aclk     (aclk),
        .stage_en (stage_en),
        .t_in     (t_red),
        .bounds   (bounds),
        .value    (red_val)
    );

    hsl_ramp u_ramp_green (
        .aclk     (aclk),
        .stage_en (stage_en),
        .t_in     (t_green),
        .bounds   (bounds),
        .value    (green_val)
    );

    hsl_ramp u_ramp_blue (
        .aclk     (aclk),
        .stage_en (stage_en),
        .t_in     (t_blue),
        .bounds   (bounds),
        .value    (blue_val)
    );

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];
    assign m_red   = FIELD_W'(red_val);
    assign m_green = FIELD_W'(green_val);
    assign m_blue  = FIELD_W'(blue_val);

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (vld_reg == '1))
        else $error("Input stalled while a pipeline stage was empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("Accepted pixel did not enter the first stage.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (red_val <= ONE && green_val <= ONE && blue_val <= ONE))
        else $error("Channel value above full scale.");

endmodule
